>>> hw/rtl/cslt_pkg.sv
// ----------------------------------------------------------------------------
// cslt_pkg
// shared codes and the command record passed from front to back
// ----------------------------------------------------------------------------
package cslt_pkg;

	typedef enum logic [1:0] {
		MODE_ADD      = 2'd0,
		MODE_SUBMIT   = 2'd1,
		MODE_COMPLETE = 2'd2,
		MODE_VERIFY   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		LIST_FREE   = 2'd0,
		LIST_PEND   = 2'd1,
		LIST_FLIGHT = 2'd2,
		LIST_DONE   = 2'd3
	} list_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_EMPTY      = 2'd1,
		ST_NOT_FLIGHT = 2'd2
	} status_t;

	typedef struct packed {
		logic       named;
		logic       store;
		logic       fetch;
		logic       in_range;
		list_t      src;
		list_t      dst;
		logic [7:0] slot;
	} cmd_t;

endpackage

>>> hw/rtl/command_slot_lifecycle_tracker.sv
// ----------------------------------------------------------------------------
// command_slot_lifecycle_tracker
// pool of command slots moved through free, pending, in flight and done lists
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------------------
//   in       | in_valid / in_ready  | mode, slot_in, command_data
//   out      | out_valid / out_ready| status, slot_out, command_out, four counts
//   cfg      | cfg_valid / cfg_ready| verify_enable
//
// a slot move walks the idle, read, link, self, tail and finish states of the
// link sequencer and makes up to three writes each to the next and prev link rams
// a rejected item goes idle to finish, or via read and link when not in flight
// after reset a clearing pass over all SLOTS slots rebuilds the free list, no
// item is taken by the sequencer meanwhile; the front queue still takes two items
// a two entry queue and the output register let each side stall on its own
// ----------------------------------------------------------------------------
module command_slot_lifecycle_tracker #(
	parameter int SLOTS      = 256,
	parameter int DESC_WIDTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [7:0]  slot_in,
	input  logic [63:0] command_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [7:0]  slot_out,
	output logic [63:0] command_out,
	output logic [8:0]  free_count,
	output logic [8:0]  pending_count,
	output logic [8:0]  inflight_count,
	output logic [8:0]  done_count,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        verify_enable
);

	logic                  q_valid;
	logic                  q_pop;
	cslt_pkg::cmd_t        q_cmd;
	logic [DESC_WIDTH-1:0] q_desc;

	cslt_front #(.SLOTS(SLOTS), .DESC_WIDTH(DESC_WIDTH)) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.mode          (mode),
		.slot_in       (slot_in),
		.command_data  (command_data),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.verify_enable (verify_enable),
		.q_valid       (q_valid),
		.q_pop         (q_pop),
		.q_cmd         (q_cmd),
		.q_desc        (q_desc)
	);

	cslt_back #(.SLOTS(SLOTS), .DESC_WIDTH(DESC_WIDTH)) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (q_valid),
		.q_pop          (q_pop),
		.q_cmd          (q_cmd),
		.q_desc         (q_desc),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.slot_out       (slot_out),
		.command_out    (command_out),
		.free_count     (free_count),
		.pending_count  (pending_count),
		.inflight_count (inflight_count),
		.done_count     (done_count)
	);

endmodule

>>> hw/rtl/cslt_ram.sv
// ----------------------------------------------------------------------------
// cslt_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module cslt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> hw/rtl/cslt_front.sv
// ----------------------------------------------------------------------------
// cslt_front
// accepts items, classifies them into list moves, holds a two entry queue
// ----------------------------------------------------------------------------
module cslt_front #(
	parameter int SLOTS      = 256,
	parameter int DESC_WIDTH = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            mode,
	input  logic [7:0]            slot_in,
	input  logic [63:0]           command_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic                  verify_enable,
	output logic                  q_valid,
	input  logic                  q_pop,
	output cslt_pkg::cmd_t        q_cmd,
	output logic [DESC_WIDTH-1:0] q_desc
);

	localparam int IW  = $clog2(SLOTS);
	localparam int SW  = (IW > 8) ? IW : 8;
	localparam int SWX = SW + 1;

	logic                  ven_q;
	cslt_pkg::cmd_t        cmd_in;
	logic [SWX-1:0]        sin_w;
	cslt_pkg::cmd_t        qc_q [2];
	logic [DESC_WIDTH-1:0] qd_q [2];
	logic                  wp_q;
	logic                  rp_q;
	logic [1:0]            cnt_q;
	logic                  push;

	assign cfg_ready = 1'b1;
	assign sin_w     = SWX'(slot_in);
	assign in_ready  = (cnt_q != 2'd2);
	assign push      = in_valid && in_ready;
	assign q_valid   = (cnt_q != 2'd0);
	assign q_cmd     = qc_q[rp_q];
	assign q_desc    = qd_q[rp_q];

	always_comb begin
		cmd_in          = '0;
		cmd_in.slot     = slot_in;
		cmd_in.in_range = (sin_w < SWX'(SLOTS));
		case (cslt_pkg::mode_t'(mode))
			cslt_pkg::MODE_ADD: begin
				cmd_in.src   = cslt_pkg::LIST_FREE;
				cmd_in.dst   = cslt_pkg::LIST_PEND;
				cmd_in.store = 1'b1;
			end
			cslt_pkg::MODE_SUBMIT: begin
				cmd_in.src   = cslt_pkg::LIST_PEND;
				cmd_in.dst   = cslt_pkg::LIST_FLIGHT;
				cmd_in.fetch = 1'b1;
			end
			cslt_pkg::MODE_COMPLETE: begin
				cmd_in.src   = cslt_pkg::LIST_FLIGHT;
				cmd_in.dst   = ven_q ? cslt_pkg::LIST_DONE : cslt_pkg::LIST_FREE;
				cmd_in.named = 1'b1;
			end
			default: begin
				cmd_in.src   = cslt_pkg::LIST_DONE;
				cmd_in.dst   = cslt_pkg::LIST_FREE;
				cmd_in.fetch = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ven_q <= 1'b0;
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (cfg_valid) begin
				ven_q <= verify_enable;
			end
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (q_pop) begin
				rp_q <= ~rp_q;
			end
			if (push && !q_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (!push && q_pop) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			qc_q[wp_q] <= cmd_in;
			qd_q[wp_q] <= DESC_WIDTH'(command_data);
		end
	end

endmodule

>>> hw/rtl/cslt_back.sv
// ----------------------------------------------------------------------------
// cslt_back
// link sequencer: unlinks a slot from its list and appends it to another
// ----------------------------------------------------------------------------
module cslt_back #(
	parameter int SLOTS      = 256,
	parameter int DESC_WIDTH = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	output logic                  q_pop,
	input  cslt_pkg::cmd_t        q_cmd,
	input  logic [DESC_WIDTH-1:0] q_desc,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [1:0]            status,
	output logic [7:0]            slot_out,
	output logic [63:0]           command_out,
	output logic [8:0]            free_count,
	output logic [8:0]            pending_count,
	output logic [8:0]            inflight_count,
	output logic [8:0]            done_count
);

	localparam int IW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);

	typedef enum logic [2:0] {
		S_CLR, S_IDLE, S_RD, S_LINK, S_SELF, S_TAIL, S_FIN
	} state_t;

	state_t                st_q;
	logic [IW-1:0]         clr_q;
	logic [IW-1:0]         head_q [4];
	logic [CW-1:0]         cnt_q  [4];
	cslt_pkg::cmd_t        cmd_q;
	logic [DESC_WIDTH-1:0] desc_q;
	logic [IW-1:0]         s_q;
	logic [IW-1:0]         n_q;
	logic [IW-1:0]         t_q;
	cslt_pkg::status_t     res_st_q;
	logic [7:0]            res_slot_q;
	logic [DESC_WIDTH-1:0] res_cmd_q;

	logic                  out_valid_q;
	logic [1:0]            status_q;
	logic [7:0]            slot_out_q;
	logic [63:0]           command_q;
	logic [8:0]            cnt_out_q [4];

	logic                  nx_we, pv_we, id_we, pl_we;
	logic [IW-1:0]         nx_wa, nx_wd, pv_wa, pv_wd, pv_ra, id_wa;
	logic [1:0]            id_wd;
	logic [IW-1:0]         nx_rd, pv_rd;
	logic [1:0]            id_rd;
	logic [DESC_WIDTH-1:0] pl_rd;
	logic                  link_ok;
	logic                  src_multi;
	logic                  dst_empty;
	logic [IW-1:0]         s_sel;

	assign link_ok   = !cmd_q.named || (id_rd == cslt_pkg::LIST_FLIGHT);
	assign src_multi = (cnt_q[cmd_q.src] > CW'(1));
	assign dst_empty = (cnt_q[cmd_q.dst] == '0);
	assign s_sel     = q_cmd.named ? IW'(q_cmd.slot) : head_q[q_cmd.src];
	assign q_pop     = (st_q == S_IDLE) && q_valid;

	always_comb begin
		nx_we = 1'b0;
		nx_wa = s_q;
		nx_wd = s_q;
		pv_we = 1'b0;
		pv_wa = s_q;
		pv_wd = s_q;
		pv_ra = s_q;
		id_we = 1'b0;
		id_wa = s_q;
		id_wd = cmd_q.dst;
		pl_we = 1'b0;
		case (st_q)
			S_CLR: begin
				nx_we = 1'b1;
				nx_wa = clr_q;
				nx_wd = (clr_q == IW'(SLOTS - 1)) ? '0 : clr_q + IW'(1);
				pv_we = 1'b1;
				pv_wa = clr_q;
				pv_wd = (clr_q == '0) ? IW'(SLOTS - 1) : clr_q - IW'(1);
				id_we = 1'b1;
				id_wa = clr_q;
				id_wd = cslt_pkg::LIST_FREE;
			end
			S_LINK: begin
				pv_ra = head_q[cmd_q.dst];
				if (link_ok && src_multi) begin
					nx_we = 1'b1;
					nx_wa = pv_rd;
					nx_wd = nx_rd;
					pv_we = 1'b1;
					pv_wa = nx_rd;
					pv_wd = pv_rd;
				end
			end
			S_SELF: begin
				nx_we = 1'b1;
				nx_wd = dst_empty ? s_q : head_q[cmd_q.dst];
				pv_we = 1'b1;
				pv_wd = dst_empty ? s_q : pv_rd;
				id_we = 1'b1;
				pl_we = cmd_q.store;
			end
			S_TAIL: begin
				if (!dst_empty) begin
					nx_we = 1'b1;
					nx_wa = t_q;
					pv_we = 1'b1;
					pv_wa = head_q[cmd_q.dst];
				end
			end
			default: begin
			end
		endcase
	end

	cslt_ram #(.WIDTH(IW), .DEPTH(SLOTS)) u_next (
		.clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .raddr(s_q), .rdata(nx_rd)
	);

	cslt_ram #(.WIDTH(IW), .DEPTH(SLOTS)) u_prev (
		.clk(clk), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd), .raddr(pv_ra), .rdata(pv_rd)
	);

	cslt_ram #(.WIDTH(2), .DEPTH(SLOTS)) u_list (
		.clk(clk), .we(id_we), .waddr(id_wa), .wdata(id_wd), .raddr(s_q), .rdata(id_rd)
	);

	cslt_ram #(.WIDTH(DESC_WIDTH), .DEPTH(SLOTS)) u_desc (
		.clk(clk), .we(pl_we), .waddr(s_q), .wdata(desc_q), .raddr(s_q), .rdata(pl_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_CLR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 4; i++) begin
				head_q[i] <= '0;
				cnt_q[i]  <= '0;
			end
			cnt_q[cslt_pkg::LIST_FREE] <= CW'(SLOTS);
		end else begin
			if (out_valid_q && out_ready && (st_q != S_FIN)) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				S_CLR: begin
					clr_q <= clr_q + IW'(1);
					if (clr_q == IW'(SLOTS - 1)) begin
						st_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (q_valid) begin
						cmd_q  <= q_cmd;
						desc_q <= q_desc;
						s_q    <= s_sel;
						if (q_cmd.named && !q_cmd.in_range) begin
							res_st_q   <= cslt_pkg::ST_NOT_FLIGHT;
							res_slot_q <= q_cmd.slot;
							res_cmd_q  <= '0;
							st_q       <= S_FIN;
						end else if (!q_cmd.named && cnt_q[q_cmd.src] == '0) begin
							res_st_q   <= cslt_pkg::ST_EMPTY;
							res_slot_q <= '0;
							res_cmd_q  <= '0;
							st_q       <= S_FIN;
						end else begin
							st_q <= S_RD;
						end
					end
				end
				S_RD: begin
					st_q <= S_LINK;
				end
				S_LINK: begin
					n_q        <= nx_rd;
					res_slot_q <= cmd_q.named ? cmd_q.slot : 8'(s_q);
					if (link_ok) begin
						res_st_q  <= cslt_pkg::ST_OK;
						res_cmd_q <= cmd_q.fetch ? pl_rd : '0;
						st_q      <= S_SELF;
					end else begin
						res_st_q  <= cslt_pkg::ST_NOT_FLIGHT;
						res_cmd_q <= '0;
						st_q      <= S_FIN;
					end
				end
				S_SELF: begin
					t_q  <= pv_rd;
					st_q <= S_TAIL;
				end
				S_TAIL: begin
					if (!src_multi) begin
						head_q[cmd_q.src] <= '0;
					end else if (head_q[cmd_q.src] == s_q) begin
						head_q[cmd_q.src] <= n_q;
					end
					cnt_q[cmd_q.src] <= cnt_q[cmd_q.src] - CW'(1);
					if (dst_empty) begin
						head_q[cmd_q.dst] <= s_q;
					end
					cnt_q[cmd_q.dst] <= cnt_q[cmd_q.dst] + CW'(1);
					st_q <= S_FIN;
				end
				S_FIN: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						status_q    <= res_st_q;
						slot_out_q  <= res_slot_q;
						command_q   <= 64'(res_cmd_q);
						for (int i = 0; i < 4; i++) begin
							cnt_out_q[i] <= 9'(cnt_q[i]);
						end
						st_q <= S_IDLE;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign slot_out       = slot_out_q;
	assign command_out    = command_q;
	assign free_count     = cnt_out_q[cslt_pkg::LIST_FREE];
	assign pending_count  = cnt_out_q[cslt_pkg::LIST_PEND];
	assign inflight_count = cnt_out_q[cslt_pkg::LIST_FLIGHT];
	assign done_count     = cnt_out_q[cslt_pkg::LIST_DONE];

	a_count_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(int'(cnt_q[0]) + int'(cnt_q[1]) + int'(cnt_q[2]) + int'(cnt_q[3])) == SLOTS)
		else $error("list counts do not cover the pool");

	a_no_reclear: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != S_CLR) |=> (st_q != S_CLR))
		else $error("clearing pass restarted");

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (st_q != S_IDLE))
		else $error("popped item not taken up");

	a_empty_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q == cslt_pkg::ST_EMPTY) |-> (slot_out_q == 8'd0))
		else $error("empty reject carries a slot");

endmodule
